// ===== src/tldr_pkg.sv =====
// Shared types, codes and constants of the terminal receive line discipline.
package tldr_pkg;

  // Longest read that a begin-read may arm; longer requests saturate to it.
  localparam int MAX_READ_LENGTH = 256;

  localparam int CNT_W = 9;
  localparam int CHAR_W = 8;

  // Saturation bound as seen by the 9-bit request field.
  localparam logic [CNT_W-1:0] READ_LIMIT_MAX =
    (MAX_READ_LENGTH > 511) ? 9'd511 : 9'(MAX_READ_LENGTH);

  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'h7E;

  localparam int MODE_W = 7;
  localparam int MODE_CRLF = 0;
  localparam int MODE_RAW = 1;
  localparam int MODE_CBREAK = 2;
  localparam int MODE_ECHO = 3;
  localparam int MODE_ANYRES = 4;
  localparam int MODE_NONBLK = 5;
  localparam int MODE_PEER = 6;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_BEGIN = 2'd1,
    KIND_POLL  = 2'd2
  } tldr_kind_t;

  typedef enum logic [1:0] {
    SIG_NONE = 2'd0,
    SIG_INTR = 2'd1,
    SIG_TERM = 2'd2
  } tldr_sig_t;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_INTR  = 3'd1,
    REG_QUIT  = 3'd2,
    REG_STOP  = 3'd3,
    REG_START = 3'd4,
    REG_ERASE = 3'd5,
    REG_KILL  = 3'd6
  } tldr_reg_t;

  typedef struct packed {
    tldr_kind_t        kind;
    logic [CHAR_W-1:0] rx_char;
    logic [7:0]        rx_error_bits;
    logic [CNT_W-1:0]  request_length;
  } tldr_in_t;

  typedef struct packed {
    logic              store_valid;
    logic [7:0]        store_index;
    logic [CHAR_W-1:0] store_char;
    logic              echo_valid;
    logic [CNT_W-1:0]  erase_echo_count;
    tldr_sig_t         signal_raised;
    logic              peer_blocked;
    logic              read_done;
    logic [CNT_W-1:0]  done_count;
    logic              would_block;
    logic [7:0]        rx_status;
  } tldr_out_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode_flags;
    logic [CHAR_W-1:0] interrupt_char;
    logic [CHAR_W-1:0] quit_char;
    logic [CHAR_W-1:0] stop_char;
    logic [CHAR_W-1:0] start_char;
    logic [CHAR_W-1:0] erase_char;
    logic [CHAR_W-1:0] kill_char;
  } tldr_cfg_t;

  typedef struct packed {
    logic             read_active;
    logic [CNT_W-1:0] fill_index;
    logic [CNT_W-1:0] read_limit;
    logic [7:0]       sticky_status;
    logic             peer_block;
  } tldr_state_t;

endpackage

// ===== src/tty_line_discipline_receive.sv =====
// Top level of the terminal receive line discipline: input register, step logic, result register.
//
//   port group   direction  handshake           payload
//   in_*         in         in_valid/in_stall   tldr_in_t   (kind, rx_char, error bits, length)
//   out_*        out        out_valid/out_stall tldr_out_t  (store, echo, erase, signal, done)
//   cfg_*        in         cfg_we              index 0..6, 8-bit data
//
// One item per cycle while out_stall is low. An accepted transfer lands in the input register;
// the step logic then decides it against the state registers and loads the result register once
// that register frees up. Kill editing is folded into a removed-character count, so no item takes
// longer than one pass.
// Reset (rst_n low, synchronous) clears the state, both valid flags and loads register
// defaults. An out_stall holds the result register and, through it, the input register;
// in_stall rises only when the input register is full and cannot advance.
module tty_line_discipline_receive (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  tldr_pkg::tldr_in_t   in_data,

  output logic                 out_valid,
  input  logic                 out_stall,
  output tldr_pkg::tldr_out_t  out_data,

  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_wdata
);

  tldr_pkg::tldr_cfg_t   cfg;

  // input register
  logic                  in_valid_r;
  logic                  in_valid_nxt;
  tldr_pkg::tldr_in_t    in_data_r;

  // line state
  tldr_pkg::tldr_state_t state_r;
  tldr_pkg::tldr_state_t state_nxt;
  tldr_pkg::tldr_state_t step_state;

  // result register
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  tldr_pkg::tldr_out_t   out_data_r;
  tldr_pkg::tldr_out_t   step_res;

  logic                  advance;
  logic                  fire;

  tldr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tldr_step u_step (
    .item   (in_data_r),
    .cfg    (cfg),
    .st     (state_r),
    .res    (step_res),
    .st_nxt (step_state)
  );

  // The result register frees up when empty or when its transfer completes this cycle.
  assign advance  = !out_valid_r || !out_stall;
  // Commit the held item: update state and load its result.
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (!in_stall) begin
      in_valid_nxt = in_valid;
    end
    if (fire) begin
      state_nxt     = step_state;
      out_valid_nxt = 1'b1;
    end else if (advance) begin
      // result taken (or never there) and nothing new: drop valid
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // The fill position never runs past the armed limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.fill_index <= state_r.read_limit)
    else $error("fill index beyond read limit");

  // The armed limit never exceeds the saturation bound.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.read_limit <= tldr_pkg::READ_LIMIT_MAX)
    else $error("read limit above maximum");

  // A would-block result is always a completion with zero count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.would_block |->
      out_data_r.read_done && (out_data_r.done_count == '0))
    else $error("would_block without empty completion");

  // Echo only ever accompanies a store.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.echo_valid |-> out_data_r.store_valid)
    else $error("echo without store");

  // A stalled input register holds its item until the result side frees up.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r && $stable(in_data_r))
    else $error("input register lost a held item");
`endif

endmodule

// ===== src/tldr_cfg_regs.sv =====
// Configuration register file of the line discipline.
module tldr_cfg_regs (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [7:0]              cfg_wdata,
  output tldr_pkg::tldr_cfg_t     cfg
);

  tldr_pkg::tldr_cfg_t cfg_r;
  tldr_pkg::tldr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tldr_pkg::REG_MODE:  cfg_nxt.mode_flags = cfg_wdata[tldr_pkg::MODE_W-1:0];
        tldr_pkg::REG_INTR:  cfg_nxt.interrupt_char = cfg_wdata;
        tldr_pkg::REG_QUIT:  cfg_nxt.quit_char = cfg_wdata;
        tldr_pkg::REG_STOP:  cfg_nxt.stop_char = cfg_wdata;
        tldr_pkg::REG_START: cfg_nxt.start_char = cfg_wdata;
        tldr_pkg::REG_ERASE: cfg_nxt.erase_char = cfg_wdata;
        tldr_pkg::REG_KILL:  cfg_nxt.kill_char = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_flags     <= '0;
      cfg_r.interrupt_char <= 8'd3;
      cfg_r.quit_char      <= 8'd28;
      cfg_r.stop_char      <= 8'd19;
      cfg_r.start_char     <= 8'd17;
      cfg_r.erase_char     <= 8'd8;
      cfg_r.kill_char      <= 8'd21;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/tldr_step.sv =====
// Per-item decision logic: one item plus current state gives one result and next state.
module tldr_step (
  input  tldr_pkg::tldr_in_t    item,
  input  tldr_pkg::tldr_cfg_t   cfg,
  input  tldr_pkg::tldr_state_t st,
  output tldr_pkg::tldr_out_t   res,
  output tldr_pkg::tldr_state_t st_nxt
);

  logic                          peer;
  logic                          echo_on;
  logic                          raw;
  logic                          cbreak;
  logic                          line_end;
  logic                          swallow;
  logic [tldr_pkg::CHAR_W-1:0]   c;
  logic [tldr_pkg::CNT_W-1:0]    req;
  logic [tldr_pkg::CNT_W-1:0]    erased;
  logic [tldr_pkg::CNT_W-1:0]    fill;

  always_comb begin
    peer     = cfg.mode_flags[tldr_pkg::MODE_PEER];
    echo_on  = cfg.mode_flags[tldr_pkg::MODE_ECHO];
    raw      = cfg.mode_flags[tldr_pkg::MODE_RAW];
    cbreak   = cfg.mode_flags[tldr_pkg::MODE_CBREAK];
    line_end = 1'b0;
    swallow  = 1'b0;
    erased   = '0;
    fill     = st.fill_index;
    c        = item.rx_char;
    req      = item.request_length;
    st_nxt   = st;
    res      = '0;

    case (item.kind)
      tldr_pkg::KIND_BEGIN: begin
        if (req > tldr_pkg::READ_LIMIT_MAX) begin
          req = tldr_pkg::READ_LIMIT_MAX;
        end
        st_nxt.fill_index  = '0;
        st_nxt.read_limit  = req;
        st_nxt.read_active = (req != '0);
        res.read_done      = (req == '0);
      end

      tldr_pkg::KIND_POLL: begin
        if (st.read_active && cfg.mode_flags[tldr_pkg::MODE_NONBLK]) begin
          st_nxt.read_active = 1'b0;
          res.read_done      = 1'b1;
          res.done_count     = st.fill_index;
          res.would_block    = (st.fill_index == '0);
        end
      end

      tldr_pkg::KIND_CHAR: begin
        if (st.read_active) begin
          st_nxt.sticky_status = st.sticky_status | item.rx_error_bits;
          if (c == tldr_pkg::CHAR_CR && cfg.mode_flags[tldr_pkg::MODE_CRLF]) begin
            c = tldr_pkg::CHAR_LF;
          end
          if (!raw) begin
            if (peer && cfg.mode_flags[tldr_pkg::MODE_ANYRES]) begin
              st_nxt.peer_block = 1'b0;
            end
            line_end = (c == tldr_pkg::CHAR_LF);
            if (c == cfg.interrupt_char) begin
              res.signal_raised = tldr_pkg::SIG_INTR;
            end else if (c == cfg.quit_char) begin
              res.signal_raised = tldr_pkg::SIG_TERM;
            end else if (c == cfg.stop_char) begin
              if (peer) st_nxt.peer_block = 1'b1;
              swallow = 1'b1;
            end else if (c == cfg.start_char) begin
              if (peer) st_nxt.peer_block = 1'b0;
              swallow = 1'b1;
            end
            if (!swallow && !cbreak) begin
              if (c == cfg.erase_char) begin
                if (fill != '0) begin
                  fill   = fill - 9'd1;
                  erased = 9'd1;
                end
                swallow = 1'b1;
              end else if (c == cfg.kill_char) begin
                erased  = fill;
                fill    = '0;
                swallow = 1'b1;
              end
            end
          end
          if (echo_on && peer) begin
            res.erase_echo_count = erased;
          end
          if (!swallow) begin
            res.store_valid = 1'b1;
            res.store_index = fill[7:0];
            res.store_char  = c;
            res.echo_valid  = echo_on && peer &&
                              (c >= tldr_pkg::CHAR_PRINT_LO) &&
                              (c <= tldr_pkg::CHAR_PRINT_HI);
            fill = fill + 9'd1;
          end
          st_nxt.fill_index = fill;
          if (line_end || (fill >= st.read_limit)) begin
            st_nxt.read_active = 1'b0;
            res.read_done      = 1'b1;
            res.done_count     = fill;
          end
        end
      end

      default: begin
        // unused kind code: report status only
        st_nxt = st;
      end
    endcase

    res.peer_blocked = st_nxt.peer_block;
    res.rx_status    = st_nxt.sticky_status;
  end

endmodule

// ===== test/tldr_rx_checker.sv =====
// Line discipline checker: predicts each result from accepted transfers and compares it.
module tldr_rx_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  tldr_pkg::tldr_in_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  tldr_pkg::tldr_out_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_wdata,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tldr_pkg::*;

  tldr_cfg_t   regs;
  tldr_state_t rx_line;
  tldr_out_t   results_due[$];
  int          fail_count = 0;
  int          outstanding = 0;

  assign errors = fail_count;
  assign pending = outstanding;

  task automatic report(string msg);
    $display("%0t tldr_rx_checker: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare(string field, int unsigned got, int unsigned want);
    if (got != want) begin
      report($sformatf("%s is %0d, expected %0d", field, got, want));
    end
  endtask

  // Advance the line state by one item and return the result it causes.
  function automatic tldr_out_t step_line(tldr_in_t item);
    tldr_out_t        r;
    logic [CNT_W-1:0] req;
    logic [CHAR_W-1:0] ch;
    logic             peer;
    logic             echo_on;
    logic             line_end;
    logic             swallow;
    r = '0;
    peer = regs.mode_flags[MODE_PEER];
    echo_on = regs.mode_flags[MODE_ECHO];
    line_end = 1'b0;
    swallow = 1'b0;
    ch = item.rx_char;
    case (item.kind)
      KIND_BEGIN: begin
        req = (item.request_length > READ_LIMIT_MAX) ? READ_LIMIT_MAX : item.request_length;
        rx_line.fill_index = '0;
        rx_line.read_limit = req;
        rx_line.read_active = (req != '0);
        r.read_done = (req == '0);
      end
      KIND_POLL: begin
        if (rx_line.read_active && regs.mode_flags[MODE_NONBLK]) begin
          rx_line.read_active = 1'b0;
          r.read_done = 1'b1;
          if (rx_line.fill_index != '0) r.done_count = rx_line.fill_index;
          else r.would_block = 1'b1;
        end
      end
      KIND_CHAR: begin
        if (rx_line.read_active) begin
          rx_line.sticky_status |= item.rx_error_bits;
          if (ch == CHAR_CR && regs.mode_flags[MODE_CRLF]) ch = CHAR_LF;
          if (!regs.mode_flags[MODE_RAW]) begin
            if (peer && regs.mode_flags[MODE_ANYRES]) rx_line.peer_block = 1'b0;
            line_end = (ch == CHAR_LF);
            if (ch == regs.interrupt_char) begin
              r.signal_raised = SIG_INTR;
            end else if (ch == regs.quit_char) begin
              r.signal_raised = SIG_TERM;
            end else if (ch == regs.stop_char) begin
              if (peer) rx_line.peer_block = 1'b1;
              swallow = 1'b1;
            end else if (ch == regs.start_char) begin
              if (peer) rx_line.peer_block = 1'b0;
              swallow = 1'b1;
            end
            if (!swallow && !regs.mode_flags[MODE_CBREAK]) begin
              if (ch == regs.erase_char) begin
                if (rx_line.fill_index != '0) begin
                  rx_line.fill_index--;
                  r.erase_echo_count = 9'd1;
                end
                swallow = 1'b1;
              end else if (ch == regs.kill_char) begin
                r.erase_echo_count = rx_line.fill_index;
                rx_line.fill_index = '0;
                swallow = 1'b1;
              end
            end
          end
          if (!(echo_on && peer)) r.erase_echo_count = '0;
          if (!swallow) begin
            r.store_valid = 1'b1;
            r.store_index = rx_line.fill_index[7:0];
            r.store_char = ch;
            rx_line.fill_index++;
            r.echo_valid = echo_on && peer && ch >= CHAR_PRINT_LO && ch <= CHAR_PRINT_HI;
          end
          if (line_end || rx_line.fill_index >= rx_line.read_limit) begin
            rx_line.read_active = 1'b0;
            r.read_done = 1'b1;
            r.done_count = rx_line.fill_index;
          end
        end
      end
      default: ;
    endcase
    r.peer_blocked = rx_line.peer_block;
    r.rx_status = rx_line.sticky_status;
    return r;
  endfunction

  always @(posedge clk) begin
    tldr_out_t want;
    if (!rst_n) begin
      regs = '{mode_flags: '0, interrupt_char: 8'd3, quit_char: 8'd28, stop_char: 8'd19,
               start_char: 8'd17, erase_char: 8'd8, kill_char: 8'd21};
      rx_line = '0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (tldr_reg_t'(cfg_index))
          REG_MODE:  regs.mode_flags = cfg_wdata[MODE_W-1:0];
          REG_INTR:  regs.interrupt_char = cfg_wdata;
          REG_QUIT:  regs.quit_char = cfg_wdata;
          REG_STOP:  regs.stop_char = cfg_wdata;
          REG_START: regs.start_char = cfg_wdata;
          REG_ERASE: regs.erase_char = cfg_wdata;
          REG_KILL:  regs.kill_char = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) results_due.push_back(step_line(in_data));
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report("result transfer with no result due");
        end else begin
          want = results_due.pop_front();
          compare("store_valid", out_data.store_valid, want.store_valid);
          compare("store_index", out_data.store_index, want.store_index);
          compare("store_char", out_data.store_char, want.store_char);
          compare("echo_valid", out_data.echo_valid, want.echo_valid);
          compare("erase_echo_count", out_data.erase_echo_count, want.erase_echo_count);
          compare("signal_raised", out_data.signal_raised, want.signal_raised);
          compare("peer_blocked", out_data.peer_blocked, want.peer_blocked);
          compare("read_done", out_data.read_done, want.read_done);
          compare("done_count", out_data.done_count, want.done_count);
          compare("would_block", out_data.would_block, want.would_block);
          compare("rx_status", out_data.rx_status, want.rx_status);
        end
      end
    end
    outstanding = results_due.size();
  end

endmodule

// ===== test/tty_line_discipline_receive_tb.sv =====
// Top of the line discipline testbench: clock, reset, register setup, traffic and verdict.
module tty_line_discipline_receive_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tldr_pkg::*;

  // Kind code the block does not define; it must only report status.
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  // Cycles without any transfer before the run is declared hung.
  localparam int HANG_LIMIT = 1000;
  // Cycles to keep watching the result channel after the last result.
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tldr_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  tldr_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;

  int          errors;
  int          pending;
  int          quiet_cycles = 0;
  int          items_sent = 0;
  bit          steady = 1'b0;   // set: no gaps on either side
  tldr_cfg_t   cur_cfg;

  always #5 clk = ~clk;

  tty_line_discipline_receive u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tldr_rx_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  // Watchdog: any transfer on either channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("tty_line_discipline_receive_tb: done, errors");
      $finish;
    end
  end

  // Gap length: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver back-pressure: alternate stall and ready runs of random length.
  // Only one assignment to out_stall per falling edge.
  initial begin
    int run;
    run = 0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_stall <= 1'b0;
        run = 0;
      end else if (run > 0) begin
        run--;
      end else if (out_stall) begin
        out_stall <= 1'b0;
        run = $urandom_range(0, 12);
      end else begin
        out_stall <= 1'b1;
        run = pick_gap();
      end
    end
  end

  function automatic tldr_in_t make_item(logic [1:0] kind, logic [7:0] ch, logic [7:0] err,
                                         logic [8:0] len);
    tldr_in_t r;
    r.kind = tldr_kind_t'(kind);
    r.rx_char = ch;
    r.rx_error_bits = err;
    r.request_length = len;
    return r;
  endfunction

  // Present one transfer at a falling edge and hold it until accepted.
  // Return at the falling edge after the accepting rising edge.
  task automatic send(tldr_in_t item);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Unused fields of each kind carry random noise.
  task automatic begin_read(logic [8:0] len);
    send(make_item(KIND_BEGIN, 8'($urandom), 8'($urandom), len));
  endtask

  task automatic rx(logic [7:0] ch, logic [7:0] err);
    send(make_item(KIND_CHAR, ch, err, 9'($urandom)));
  endtask

  task automatic poll();
    send(make_item(KIND_POLL, 8'($urandom), 8'($urandom), 9'($urandom)));
  endtask

  // Drop valid and wait until every result has been transferred.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write all registers back to back; hold the enable across the burst.
  task automatic write_config(tldr_cfg_t c);
    logic [7:0] vals [7];
    vals = '{{1'($urandom), c.mode_flags}, c.interrupt_char, c.quit_char, c.stop_char,
             c.start_char, c.erase_char, c.kill_char};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= tldr_reg_t'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  // Character mix weighted toward the ones the discipline acts on.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 15))
      0:       return cur_cfg.interrupt_char;
      1:       return cur_cfg.quit_char;
      2:       return cur_cfg.stop_char;
      3:       return cur_cfg.start_char;
      4, 5:    return cur_cfg.erase_char;
      6:       return cur_cfg.kill_char;
      7:       return CHAR_CR;
      8:       return CHAR_LF;
      9:       return 8'($urandom);
      default: return 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
    endcase
  endfunction

  function automatic logic [7:0] pick_err();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
  endfunction

  // Control characters for a register: extremes, line codes or anything.
  function automatic logic [7:0] pick_ctl_char();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return CHAR_LF;
      3:       return CHAR_CR;
      4:       return 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
      5:       return 8'($urandom);
      default: return 8'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic tldr_cfg_t random_cfg();
    tldr_cfg_t c;
    c.mode_flags = 7'($urandom);
    // Keep raw mode rare so editing and flow control see most traffic.
    if ($urandom_range(0, 3) != 0) c.mode_flags[MODE_RAW] = 1'b0;
    c.interrupt_char = pick_ctl_char();
    c.quit_char = pick_ctl_char();
    c.stop_char = pick_ctl_char();
    c.start_char = pick_ctl_char();
    c.erase_char = pick_ctl_char();
    c.kill_char = pick_ctl_char();
    return c;
  endfunction

  // One read: arm it, then feed characters with an occasional poll.
  task automatic line_burst();
    int r;
    int len;
    int n;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(1, 16);
    else if (r < 80) len = $urandom_range(17, 64);
    else if (r < 85) len = 0;
    else if (r < 90) len = $urandom_range(MAX_READ_LENGTH, 511);
    else len = $urandom_range(1, 4);
    begin_read(9'(len));
    n = (len == 0) ? $urandom_range(0, 1) : $urandom_range(1, ((len < 24) ? len : 24) + 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) poll();
      else rx(pick_char(), pick_err());
    end
  endtask

  // Mostly well-formed reads, the rest stray polls and junk items.
  task automatic traffic(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 85) begin
        line_burst();
      end else begin
        case ($urandom_range(0, 2))
          0:       poll();
          1:       send(make_item(KIND_UNKNOWN, 8'($urandom), 8'($urandom), 9'($urandom)));
          default: send(make_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                                  9'($urandom)));
        endcase
      end
    end
  endtask

  initial begin
    tldr_cfg_t c;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset values, no peer: editing and signals without any echo.
    c = '{mode_flags: '0, interrupt_char: 8'd3, quit_char: 8'd28, stop_char: 8'd19,
          start_char: 8'd17, erase_char: 8'd8, kill_char: 8'd21};
    write_config(c);
    begin_read(9'd0);                        // empty read completes at once
    begin_read(9'h1FF);                      // oversize request saturates
    rx(8'h41, 8'h00);
    rx(CHAR_CR, 8'h01);                      // no mapping: CR is stored
    rx(cur_cfg.interrupt_char, 8'h00);       // signal raised, still stored
    rx(cur_cfg.quit_char, 8'h00);
    rx(cur_cfg.stop_char, 8'h00);            // swallowed, no peer to block
    rx(cur_cfg.start_char, 8'h00);
    rx(cur_cfg.erase_char, 8'h00);           // removed silently without echo
    rx(cur_cfg.kill_char, 8'h00);
    rx(8'hFF, 8'hFF);                        // all status bits stick
    rx(CHAR_LF, 8'h00);                      // line end completes the read
    rx(8'h7A, 8'h40);                        // no read armed: dropped
    poll();                                  // blocking poll does nothing
    send(make_item(KIND_UNKNOWN, 8'h00, 8'h00, 9'd0));

    // Echo with a peer, CR mapping, any-character resume, nonblocking polls.
    settle();
    c.mode_flags = '0;
    c.mode_flags[MODE_CRLF] = 1'b1;
    c.mode_flags[MODE_ECHO] = 1'b1;
    c.mode_flags[MODE_ANYRES] = 1'b1;
    c.mode_flags[MODE_NONBLK] = 1'b1;
    c.mode_flags[MODE_PEER] = 1'b1;
    write_config(c);
    begin_read(9'd5);
    poll();                                  // nothing read: would block
    begin_read(9'd20);
    rx(8'h61, 8'h00);
    rx(8'h62, 8'h00);
    rx(cur_cfg.kill_char, 8'h00);            // two removals echoed
    rx(cur_cfg.erase_char, 8'h00);           // empty line: nothing to remove
    rx(cur_cfg.stop_char, 8'h00);            // peer output blocked
    rx(8'h78, 8'h00);                        // any character resumes
    begin_read(9'd3);                        // abandon the open read
    rx(CHAR_CR, 8'h00);                      // mapped to LF, ends the read

    // Raw mode: one full-length read of arbitrary bytes.
    settle();
    c.mode_flags = '0;
    c.mode_flags[MODE_RAW] = 1'b1;
    c.mode_flags[MODE_ECHO] = 1'b1;
    c.mode_flags[MODE_PEER] = 1'b1;
    write_config(c);
    begin_read(9'(MAX_READ_LENGTH));
    for (int i = 0; i < MAX_READ_LENGTH; i++) rx(8'($urandom), pick_err());

    // Random phases: first all-low settings, then all-high, then random ones.
    for (int p = 0; p < 8; p++) begin
      settle();
      if (p == 0) c = '0;
      else if (p == 1) c = '1;
      else c = random_cfg();
      steady = (p % 3 == 2);
      write_config(c);
      traffic(120);
    end
    steady = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tty_line_discipline_receive_tb: done, clean");
    end else begin
      $display("tty_line_discipline_receive_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tldr_pkg.sv
src/tldr_cfg_regs.sv
src/tldr_step.sv
src/tty_line_discipline_receive.sv
test/tldr_rx_checker.sv
test/tty_line_discipline_receive_tb.sv
